/* rtl/esedf_pkg.sv */
package esedf_pkg;

  localparam int BIN_ENTRIES = 64;

  localparam int QTY_W  = 16;
  localparam int LIFE_W = 16;
  localparam int WORD_W = 32;

  localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};

  // Step commands from the sequencer to the bin chain; load and prune are raised together in idle.
  typedef struct packed {
    logic load;    // capture the input item
    logic prune;   // drop the head bin if it has expired
    logic insert;  // merge or place the arrivals
    logic pop;     // consume one unit and register the result
  } esedf_cmd_t;

endpackage

/* rtl/esedf_ctrl.sv */
module esedf_ctrl
  import esedf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output esedf_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_POP
  } state_t;

  state_t state;
  logic   pop_go;

  assign in_ready = (state == S_IDLE);
  // result can only be written once the output register is free
  assign pop_go   = (state == S_POP) && (!out_valid || out_ready);

  always_comb begin
    cmd        = '0;
    cmd.load   = in_valid && in_ready;
    cmd.prune  = (state == S_IDLE);
    cmd.insert = (state == S_INSERT);
    cmd.pop    = pop_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_INSERT;
          end
        end
        S_INSERT: state <= S_POP;
        S_POP: begin
          if (pop_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/esedf_datapath.sv */
module esedf_datapath
  import esedf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  esedf_cmd_t          cmd,
  input  logic [QTY_W-1:0]    arrivals,
  input  logic [LIFE_W-1:0]   shelf_life,
  output logic                consumed,
  output logic [WORD_W-1:0]   total_consumed,
  output logic                stock_empty,
  output logic                bins_overflow
);

  // Bin chain kept sorted by expiry, occupied cells packed from cell 0.
  // Expiries are unique, so the head holds the earliest one.
  logic [WORD_W-1:0] bin_exp      [BIN_ENTRIES];
  logic [WORD_W-1:0] bin_cnt      [BIN_ENTRIES];
  logic [WORD_W-1:0] bin_exp_next [BIN_ENTRIES];
  logic [WORD_W-1:0] bin_cnt_next [BIN_ENTRIES];
  logic [BIN_ENTRIES-1:0] vld;
  logic [BIN_ENTRIES-1:0] vld_next;

  logic [WORD_W-1:0] now;
  logic [WORD_W-1:0] total;
  logic [WORD_W-1:0] new_exp;
  logic [QTY_W-1:0]  new_qty;
  logic              new_ok;
  logic              ovf;

  logic [WORD_W:0]        exp_sum;
  logic [BIN_ENTRIES-1:0] hit;
  logic [BIN_ENTRIES-1:0] gt;
  logic                   any_hit;
  logic                   full;
  logic                   ins_place;
  logic                   ovf_now;
  logic                   shift_left;
  logic                   head_done;
  logic                   head_live;
  logic [WORD_W:0]        merge_sum [BIN_ENTRIES];

  assign exp_sum = {1'b0, now} + {{(WORD_W+1-LIFE_W){1'b0}}, shelf_life} - 33'd1;

  always_comb begin
    for (int i = 0; i < BIN_ENTRIES; i++) begin
      hit[i]       = vld[i] && (bin_exp[i] == new_exp);
      gt[i]        = !vld[i] || (bin_exp[i] > new_exp);
      merge_sum[i] = {1'b0, bin_cnt[i]} + {{(WORD_W+1-QTY_W){1'b0}}, new_qty};
    end
  end

  assign any_hit   = |hit;
  assign full      = vld[BIN_ENTRIES-1];
  assign ins_place = cmd.insert && new_ok && !any_hit && !full;
  assign ovf_now   = new_ok && !any_hit && full;

  // At most one bin can newly expire per tick: the tick advances by one and
  // expiries are unique, so pruning only ever removes the head.
  assign head_done  = vld[0] && (bin_cnt[0] == 32'd1);
  assign shift_left = (cmd.prune && vld[0] && (bin_exp[0] < now)) ||
                      (cmd.pop && head_done);
  assign head_live  = vld[0] && (!head_done || vld[1]);

  always_comb begin
    for (int i = 0; i < BIN_ENTRIES; i++) begin
      bin_exp_next[i] = bin_exp[i];
      bin_cnt_next[i] = bin_cnt[i];
      vld_next[i]     = vld[i];
      if (shift_left) begin
        if (i == BIN_ENTRIES-1) begin
          vld_next[i] = 1'b0;
        end else begin
          bin_exp_next[i] = bin_exp[(i == BIN_ENTRIES-1) ? i : i+1];
          bin_cnt_next[i] = bin_cnt[(i == BIN_ENTRIES-1) ? i : i+1];
          vld_next[i]     = vld[(i == BIN_ENTRIES-1) ? i : i+1];
        end
      end else if (cmd.pop && i == 0 && vld[0]) begin
        bin_cnt_next[i] = bin_cnt[i] - 32'd1;
      end else if (cmd.insert && new_ok && hit[i]) begin
        bin_cnt_next[i] = merge_sum[i][WORD_W] ? WORD_MAX : merge_sum[i][WORD_W-1:0];
      end else if (ins_place) begin
        if (gt[i] && (i == 0 || !gt[(i == 0) ? 0 : i-1])) begin
          bin_exp_next[i] = new_exp;
          bin_cnt_next[i] = {{(WORD_W-QTY_W){1'b0}}, new_qty};
          vld_next[i]     = 1'b1;
        end else if (i > 0 && gt[(i == 0) ? 0 : i-1]) begin
          bin_exp_next[i] = bin_exp[(i == 0) ? 0 : i-1];
          bin_cnt_next[i] = bin_cnt[(i == 0) ? 0 : i-1];
          vld_next[i]     = vld[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BIN_ENTRIES; i++) begin
      bin_exp[i] <= bin_exp_next[i];
      bin_cnt[i] <= bin_cnt_next[i];
    end
    if (cmd.load) begin
      new_qty <= arrivals;
      new_ok  <= (arrivals != '0) && (shelf_life != '0);
      new_exp <= exp_sum[WORD_W] ? WORD_MAX : exp_sum[WORD_W-1:0];
    end
    if (cmd.insert) begin
      ovf <= ovf_now;
    end
    if (cmd.pop) begin
      consumed      <= vld[0];
      stock_empty   <= !head_live;
      bins_overflow <= ovf;
    end
    if (rst) begin
      vld   <= '0;
      now   <= '0;
      total <= '0;
    end else begin
      vld <= vld_next;
      if (cmd.pop) begin
        if (now != WORD_MAX) begin
          now <= now + 32'd1;
        end
        if (vld[0] && total != WORD_MAX) begin
          total <= total + 32'd1;
        end
      end
    end
  end

  // only moves when a new result is written
  assign total_consumed = total;

endmodule

/* rtl/expiring_stock_edf_consumer_core.sv */
// Channel  Handshake            Payload
// in       in_valid / in_ready   arrivals, shelf_life
// out      out_valid / out_ready consumed, total_consumed, stock_empty, bins_overflow
//
// Each item is accepted, inserted into the sorted bin chain, then popped from the head.
// The bin chain has a single update path, so a new item is taken only after the last has popped.
// The head is pruned of an expired bin on every idle cycle, including accept.
// A stalled result holds the pop step until the output register frees.
// Reset is synchronous; the bin chain starts empty.
module expiring_stock_edf_consumer_core
  import esedf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [QTY_W-1:0]    arrivals,
  input  logic [LIFE_W-1:0]   shelf_life,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                consumed,
  output logic [WORD_W-1:0]   total_consumed,
  output logic                stock_empty,
  output logic                bins_overflow
);

  esedf_cmd_t cmd;

  esedf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  esedf_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .arrivals       (arrivals),
    .shelf_life     (shelf_life),
    .consumed       (consumed),
    .total_consumed (total_consumed),
    .stock_empty    (stock_empty),
    .bins_overflow  (bins_overflow)
  );

endmodule

/* rtl/esedf_checker.sv */
module esedf_checker
  import esedf_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              consumed,
  input logic [WORD_W-1:0] total_consumed,
  input logic              stock_empty,
  input logic              bins_overflow
);

  // nothing consumed means nothing was stored
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !consumed |-> stock_empty && !bins_overflow)
    else $error("empty tick reported stock or overflow");

  // an accepted item keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // running total only ever steps by one
  a_total_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (total_consumed != $past(total_consumed)) |->
      total_consumed == $past(total_consumed) + 32'd1)
    else $error("total jumped");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(total_consumed) &&
      $stable(consumed) && $stable(stock_empty) && $stable(bins_overflow))
    else $error("stalled result changed");

endmodule

bind expiring_stock_edf_consumer_core esedf_checker u_esedf_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .consumed       (consumed),
  .total_consumed (total_consumed),
  .stock_empty    (stock_empty),
  .bins_overflow  (bins_overflow)
);
